>>> hw/rtl/cltok_pkg.sv
// shared types, codes and keyword table of the source tokenizer
`timescale 1ns / 1ps
`default_nettype none

package cltok_pkg;

    localparam logic [63:0] MAX_SOURCE_BYTES = 64'd65536;
    localparam logic [63:0] OFFSET_CAP_WIDE  =
        ((MAX_SOURCE_BYTES - 64'd1) < 64'd65535) ? (MAX_SOURCE_BYTES - 64'd1) : 64'd65535;
    localparam logic [15:0] OFFSET_CAP = OFFSET_CAP_WIDE[15:0];
    localparam logic [15:0] CAP16      = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NUM_KW      = 11;
    localparam int WORD_MAX    = 6;

    // token kinds
    localparam logic [4:0] K_INT    = 5'd0;
    localparam logic [4:0] K_FLOAT  = 5'd1;
    localparam logic [4:0] K_DOUBLE = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_BOOL   = 5'd4;
    localparam logic [4:0] K_CHAR   = 5'd5;
    localparam logic [4:0] K_ID     = 5'd6;
    localparam logic [4:0] K_NUM    = 5'd7;
    localparam logic [4:0] K_IF     = 5'd8;
    localparam logic [4:0] K_ELSE   = 5'd9;
    localparam logic [4:0] K_RETURN = 5'd10;
    localparam logic [4:0] K_ASSIGN = 5'd11;
    localparam logic [4:0] K_PLUS   = 5'd12;
    localparam logic [4:0] K_MINUS  = 5'd13;
    localparam logic [4:0] K_STAR   = 5'd14;
    localparam logic [4:0] K_DIV    = 5'd15;
    localparam logic [4:0] K_LPAREN = 5'd16;
    localparam logic [4:0] K_RPAREN = 5'd17;
    localparam logic [4:0] K_LBRACE = 5'd18;
    localparam logic [4:0] K_RBRACE = 5'd19;
    localparam logic [4:0] K_SEMI   = 5'd20;
    localparam logic [4:0] K_GT     = 5'd21;
    localparam logic [4:0] K_LT     = 5'd22;
    localparam logic [4:0] K_EQ     = 5'd23;
    localparam logic [4:0] K_NEQ    = 5'd24;
    localparam logic [4:0] K_AND    = 5'd25;
    localparam logic [4:0] K_OR     = 5'd26;
    localparam logic [4:0] K_WHILE  = 5'd27;
    localparam logic [4:0] K_FOR    = 5'd28;
    localparam logic [4:0] K_END    = 5'd29;
    localparam logic [4:0] K_ERR    = 5'd30;

    // byte classes
    localparam logic [3:0] CLS_SPACE   = 4'd0;
    localparam logic [3:0] CLS_NEWLINE = 4'd1;
    localparam logic [3:0] CLS_DIGIT   = 4'd2;
    localparam logic [3:0] CLS_ALPHA   = 4'd3;
    localparam logic [3:0] CLS_EQ      = 4'd4;
    localparam logic [3:0] CLS_BANG    = 4'd5;
    localparam logic [3:0] CLS_AMP     = 4'd6;
    localparam logic [3:0] CLS_PIPE    = 4'd7;
    localparam logic [3:0] CLS_SLASH   = 4'd8;
    localparam logic [3:0] CLS_SINGLE  = 4'd9;
    localparam logic [3:0] CLS_OTHER   = 4'd10;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_flag;
        logic [3:0] cls;
        logic [4:0] single_kind;
    } item_t;

    typedef struct packed {
        logic [7:0]  offending_byte;
        logic [15:0] start_line;
        logic [15:0] token_length;
        logic [15:0] start_offset;
        logic [4:0]  token_kind;
    } token_t;

    // keyword text, first character in the low byte, zero padded
    function automatic logic [47:0] kw_text(input int idx);
        logic [47:0] t;
        case (idx)
            0:       t = {24'd0, "t", "n", "i"};
            1:       t = {8'd0, "t", "a", "o", "l", "f"};
            2:       t = {"e", "l", "b", "u", "o", "d"};
            3:       t = {"g", "n", "i", "r", "t", "s"};
            4:       t = {16'd0, "l", "o", "o", "b"};
            5:       t = {16'd0, "r", "a", "h", "c"};
            6:       t = {32'd0, "f", "i"};
            7:       t = {16'd0, "e", "s", "l", "e"};
            8:       t = {"n", "r", "u", "t", "e", "r"};
            9:       t = {8'd0, "e", "l", "i", "h", "w"};
            10:      t = {24'd0, "r", "o", "f"};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input int idx);
        logic [2:0] l;
        case (idx)
            0, 10:       l = 3'd3;
            1, 9:        l = 3'd5;
            2, 3, 8:     l = 3'd6;
            4, 5, 7:     l = 3'd4;
            6:           l = 3'd2;
            default:     l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [4:0] kw_kind(input int idx);
        logic [4:0] k;
        case (idx)
            0:       k = K_INT;
            1:       k = K_FLOAT;
            2:       k = K_DOUBLE;
            3:       k = K_STRING;
            4:       k = K_BOOL;
            5:       k = K_CHAR;
            6:       k = K_IF;
            7:       k = K_ELSE;
            8:       k = K_RETURN;
            9:       k = K_WHILE;
            10:      k = K_FOR;
            default: k = K_ID;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] word_kind(input logic [47:0] chars,
                                             input logic [15:0] len,
                                             input logic        too_long);
        logic [4:0] k;
        k = K_ID;
        if (!too_long && len <= 16'(WORD_MAX)) begin
            for (int i = NUM_KW - 1; i >= 0; i--) begin
                if (chars == kw_text(i) && len[2:0] == kw_len(i)) begin
                    k = kw_kind(i);
                end
            end
        end
        return k;
    endfunction

    function automatic token_t make_tok(input logic [4:0]  kind,
                                        input logic [15:0] start,
                                        input logic [15:0] len,
                                        input logic [15:0] line,
                                        input logic [7:0]  bad);
        token_t t;
        t.token_kind     = kind;
        t.start_offset   = start;
        t.token_length   = len;
        t.start_line     = line;
        t.offending_byte = bad;
        return t;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/c_like_source_tokenizer.sv
// top level of the streaming source tokenizer
//
//   channel  | dir | tdata (low bit up)                                   | tlast
//   s_       | in  | source_byte[7:0]                                     | end_of_input
//   m_       | out | token_kind[4:0] start_offset[20:5] token_length[36:21]| last_of_item
//            |     | start_line[52:37] offending_byte[60:53], zero above  |
//
// one input beat per cycle while the queue has room; the back end scanner updates
// on each byte it pops, with the keyword compare against the six held characters.
// an item with two results stalls the back end until its hold slot drains.
// a beat passes the queue entry and then the output register before its first result.
// aresetn is synchronous, active low; the block is ready in the cycle after release.
// a stalled m_ side fills the four-entry queue before s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module c_like_source_tokenizer import cltok_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // source_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // token_kind, start_offset, token_length,
                                        // start_line, offending_byte
    output logic             m_tlast
);

    logic  q_full;
    logic  q_wr;
    item_t q_wr_item;
    logic  q_rd;
    logic  q_valid;
    item_t q_item;

    cltok_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_wr_item (q_wr_item)
    );

    cltok_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_item  (q_wr_item),
        .rd_en    (q_rd),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    cltok_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> hw/rtl/cltok_front.sv
// input side: takes source beats and classifies each byte into the queue
`timescale 1ns / 1ps
`default_nettype none

module cltok_front import cltok_pkg::*; (
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire logic       q_full,
    output logic            q_wr,
    output item_t           q_wr_item
);

    logic [3:0] cls;
    logic [4:0] single_kind;

    always_comb begin
        single_kind = K_ID;
        case (s_tdata)
            "+":     single_kind = K_PLUS;
            "-":     single_kind = K_MINUS;
            "*":     single_kind = K_STAR;
            "(":     single_kind = K_LPAREN;
            ")":     single_kind = K_RPAREN;
            "{":     single_kind = K_LBRACE;
            "}":     single_kind = K_RBRACE;
            ";":     single_kind = K_SEMI;
            ">":     single_kind = K_GT;
            "<":     single_kind = K_LT;
            default: single_kind = K_ID;
        endcase

        if (s_tdata == 8'h0A) begin
            cls = CLS_NEWLINE;
        end else if (s_tdata inside {[8'd9:8'd13], 8'd32}) begin
            cls = CLS_SPACE;
        end else if (s_tdata inside {["0":"9"]}) begin
            cls = CLS_DIGIT;
        end else if (s_tdata inside {["a":"z"], ["A":"Z"]}) begin
            cls = CLS_ALPHA;
        end else if (s_tdata == "=") begin
            cls = CLS_EQ;
        end else if (s_tdata == "!") begin
            cls = CLS_BANG;
        end else if (s_tdata == "&") begin
            cls = CLS_AMP;
        end else if (s_tdata == "|") begin
            cls = CLS_PIPE;
        end else if (s_tdata == "/") begin
            cls = CLS_SLASH;
        end else if (single_kind != K_ID) begin
            cls = CLS_SINGLE;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign s_tready              = !q_full;
    assign q_wr                  = s_tvalid && !q_full;
    assign q_wr_item.src_byte    = s_tdata;
    assign q_wr_item.end_flag    = s_tlast;
    assign q_wr_item.cls         = cls;
    assign q_wr_item.single_kind = single_kind;

endmodule

`default_nettype wire

>>> hw/rtl/cltok_queue.sv
// short queue of classified bytes between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module cltok_queue import cltok_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  wr_en,
    input  wire item_t wr_item,
    input  wire logic  rd_en,
    output logic       full,
    output logic       rd_valid,
    output item_t      rd_item
);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               ready_reg;
    logic               do_wr, do_rd;

    // no room while in reset
    assign full     = !ready_reg || (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            ready_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            ready_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cltok_back.sv
// back end: scanner state, token building and result output stage
`timescale 1ns / 1ps
`default_nettype none

module cltok_back import cltok_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_rd,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,
    output logic             m_tlast
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_NUMBER  = 4'd1;
    localparam logic [3:0] M_WORD    = 4'd2;
    localparam logic [3:0] M_EQ      = 4'd3;
    localparam logic [3:0] M_BANG    = 4'd4;
    localparam logic [3:0] M_AMP     = 4'd5;
    localparam logic [3:0] M_PIPE    = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;
    localparam logic [3:0] M_ERROR   = 4'd9;
    localparam logic [3:0] M_DONE    = 4'd10;

    logic [3:0]  mode_reg, mode_next;
    logic [47:0] chars_reg, chars_next;
    logic        too_long_reg, too_long_next;
    logic [15:0] pstart_reg, pstart_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] pline_reg, pline_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] line_reg, line_next;

    token_t      out_tok_reg, hold_tok_reg;
    logic        out_last_reg, hold_last_reg;
    logic        out_valid_reg, hold_valid_reg;

    token_t      toks [2];
    logic [1:0]  n_tok;
    logic        taken;
    logic        pop;
    logic        out_free;
    logic [7:0]  c;
    logic [3:0]  cls;

    assign out_free = !out_valid_reg || m_tready;
    assign pop      = q_valid && !hold_valid_reg && out_free;
    assign q_rd     = pop;
    assign c        = q_item.src_byte;
    assign cls      = q_item.cls;

    always_comb begin
        mode_next     = mode_reg;
        chars_next    = chars_reg;
        too_long_next = too_long_reg;
        pstart_next   = pstart_reg;
        plen_next     = plen_reg;
        pline_next    = pline_reg;
        offset_next   = offset_reg;
        line_next     = line_reg;
        toks[0]       = '0;
        toks[1]       = '0;
        n_tok         = '0;
        taken         = 1'b0;

        if (mode_reg == M_ERROR || mode_reg == M_DONE) begin
            n_tok = '0;
        end else if (q_item.end_flag) begin
            case (mode_reg)
                M_NUMBER: begin
                    toks[0] = make_tok(K_NUM, pstart_reg, plen_reg, pline_reg, 8'd0);
                    n_tok   = 2'd1;
                end
                M_WORD: begin
                    toks[0] = make_tok(word_kind(chars_reg, plen_reg, too_long_reg),
                                       pstart_reg, plen_reg, pline_reg, 8'd0);
                    n_tok   = 2'd1;
                end
                M_EQ: begin
                    toks[0] = make_tok(K_ASSIGN, pstart_reg, 16'd1, pline_reg, 8'd0);
                    n_tok   = 2'd1;
                end
                M_SLASH: begin
                    toks[0] = make_tok(K_DIV, pstart_reg, 16'd1, pline_reg, 8'd0);
                    n_tok   = 2'd1;
                end
                M_BANG: begin
                    toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "!");
                    n_tok     = 2'd1;
                    mode_next = M_ERROR;
                end
                M_AMP: begin
                    toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "&");
                    n_tok     = 2'd1;
                    mode_next = M_ERROR;
                end
                M_PIPE: begin
                    toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "|");
                    n_tok     = 2'd1;
                    mode_next = M_ERROR;
                end
                default: begin
                end
            endcase
            if (mode_next != M_ERROR) begin
                toks[n_tok[0]] = make_tok(K_END, offset_reg, 16'd0, line_reg, 8'd0);
                n_tok          = n_tok + 2'd1;
                mode_next      = M_DONE;
            end
        end else begin
            case (mode_reg)
                M_NUMBER: begin
                    if (cls == CLS_DIGIT) begin
                        if (plen_reg < CAP16) plen_next = plen_reg + 16'd1;
                        taken = 1'b1;
                    end else begin
                        toks[0]   = make_tok(K_NUM, pstart_reg, plen_reg, pline_reg, 8'd0);
                        n_tok     = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_WORD: begin
                    if (cls == CLS_ALPHA || cls == CLS_DIGIT) begin
                        if (plen_reg < 16'(WORD_MAX)) begin
                            chars_next[plen_reg[2:0]*8 +: 8] = c;
                        end else begin
                            too_long_next = 1'b1;
                        end
                        if (plen_reg < CAP16) plen_next = plen_reg + 16'd1;
                        taken = 1'b1;
                    end else begin
                        toks[0]   = make_tok(word_kind(chars_reg, plen_reg, too_long_reg),
                                             pstart_reg, plen_reg, pline_reg, 8'd0);
                        n_tok     = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_EQ: begin
                    if (cls == CLS_EQ) begin
                        toks[0] = make_tok(K_EQ, pstart_reg, 16'd2, pline_reg, 8'd0);
                        taken   = 1'b1;
                    end else begin
                        toks[0] = make_tok(K_ASSIGN, pstart_reg, 16'd1, pline_reg, 8'd0);
                    end
                    n_tok     = 2'd1;
                    mode_next = M_IDLE;
                end
                M_BANG: begin
                    if (cls == CLS_EQ) begin
                        toks[0]   = make_tok(K_NEQ, pstart_reg, 16'd2, pline_reg, 8'd0);
                        mode_next = M_IDLE;
                    end else begin
                        toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "!");
                        mode_next = M_ERROR;
                    end
                    n_tok = 2'd1;
                    taken = 1'b1;
                end
                M_AMP: begin
                    if (cls == CLS_AMP) begin
                        toks[0]   = make_tok(K_AND, pstart_reg, 16'd2, pline_reg, 8'd0);
                        mode_next = M_IDLE;
                    end else begin
                        toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "&");
                        mode_next = M_ERROR;
                    end
                    n_tok = 2'd1;
                    taken = 1'b1;
                end
                M_PIPE: begin
                    if (cls == CLS_PIPE) begin
                        toks[0]   = make_tok(K_OR, pstart_reg, 16'd2, pline_reg, 8'd0);
                        mode_next = M_IDLE;
                    end else begin
                        toks[0]   = make_tok(K_ERR, pstart_reg, 16'd1, pline_reg, "|");
                        mode_next = M_ERROR;
                    end
                    n_tok = 2'd1;
                    taken = 1'b1;
                end
                M_SLASH: begin
                    if (cls == CLS_SLASH) begin
                        mode_next = M_COMMENT;
                        taken     = 1'b1;
                    end else begin
                        toks[0]   = make_tok(K_DIV, pstart_reg, 16'd1, pline_reg, 8'd0);
                        n_tok     = 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_COMMENT: begin
                    if (cls == CLS_NEWLINE) begin
                        if (line_reg < CAP16) line_next = line_reg + 16'd1;
                        mode_next = M_IDLE;
                    end
                    taken = 1'b1;
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase

            // from idle: skip space, count a newline, start a token, or emit a single or error token
            if (!taken && mode_next == M_IDLE) begin
                case (cls)
                    CLS_SPACE: begin
                    end
                    CLS_NEWLINE: begin
                        if (line_reg < CAP16) line_next = line_reg + 16'd1;
                    end
                    CLS_DIGIT, CLS_ALPHA, CLS_EQ, CLS_BANG, CLS_AMP, CLS_PIPE,
                    CLS_SLASH: begin
                        pstart_next = offset_reg;
                        plen_next   = 16'd1;
                        pline_next  = line_reg;
                        case (cls)
                            CLS_DIGIT: mode_next = M_NUMBER;
                            CLS_ALPHA: begin
                                mode_next     = M_WORD;
                                chars_next    = {40'd0, c};
                                too_long_next = 1'b0;
                            end
                            CLS_EQ:    mode_next = M_EQ;
                            CLS_BANG:  mode_next = M_BANG;
                            CLS_AMP:   mode_next = M_AMP;
                            CLS_PIPE:  mode_next = M_PIPE;
                            default:   mode_next = M_SLASH;
                        endcase
                    end
                    CLS_SINGLE: begin
                        toks[n_tok[0]] = make_tok(q_item.single_kind, offset_reg, 16'd1,
                                                  line_reg, 8'd0);
                        n_tok          = n_tok + 2'd1;
                    end
                    default: begin
                        toks[n_tok[0]] = make_tok(K_ERR, offset_reg, 16'd1, line_reg, c);
                        n_tok          = n_tok + 2'd1;
                        mode_next      = M_ERROR;
                    end
                endcase
            end

            if (offset_reg < OFFSET_CAP) offset_next = offset_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            chars_reg    <= '0;
            too_long_reg <= 1'b0;
            pstart_reg   <= '0;
            plen_reg     <= '0;
            pline_reg    <= 16'd1;
            offset_reg   <= '0;
            line_reg     <= 16'd1;
        end else if (pop) begin
            mode_reg     <= mode_next;
            chars_reg    <= chars_next;
            too_long_reg <= too_long_next;
            pstart_reg   <= pstart_next;
            plen_reg     <= plen_next;
            pline_reg    <= pline_next;
            offset_reg   <= offset_next;
            line_reg     <= line_next;
        end
    end

    // output register plus one hold slot for the second beat of an item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (pop && n_tok != 2'd0) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= (n_tok == 2'd2);
            end else if (hold_valid_reg && out_free) begin
                out_valid_reg  <= 1'b1;
                hold_valid_reg <= 1'b0;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && n_tok != 2'd0) begin
            out_tok_reg   <= toks[0];
            out_last_reg  <= (n_tok == 2'd1);
            hold_tok_reg  <= toks[1];
            hold_last_reg <= 1'b1;
        end else if (hold_valid_reg && out_free) begin
            out_tok_reg   <= hold_tok_reg;
            out_last_reg  <= hold_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_tok_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
